// ===== hw/rtl/csupc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package csupc_pkg;

  localparam int NUM_COORDS = 7;
  localparam int NUM_ELEMS  = 12;
  localparam int NUM_PERMS  = 5040;
  localparam int COORD_W    = 3;
  localparam int VEC_W      = 7;
  localparam int MASK_W     = 128;
  localparam int HALF_W     = 64;
  localparam int PERM_IDX_W = 13;
  localparam int IN_DATA_W  = 88;

  typedef logic [VEC_W-1:0]              vec_t;
  typedef logic [COORD_W-1:0]            coord_t;
  typedef coord_t [NUM_COORDS-1:0]       perm_map_t;
  typedef vec_t [NUM_ELEMS-1:0]          vec_set_t;
  typedef logic [MASK_W-1:0]             mask_t;
  typedef logic [PERM_IDX_W-1:0]         perm_idx_t;

  // travels alongside each permutation through the stages
  typedef struct packed {
    logic valid;
    logic last;
  } stage_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/csupc_perm_gen.sv =====
`timescale 1ns / 1ps
`default_nettype none

module csupc_perm_gen
  import csupc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output perm_map_t       map,
  output stage_ctl_t      ctl
);

  // factorial-base counter: digit j has radix NUM_COORDS - j
  coord_t [NUM_COORDS-1:0] digit;
  coord_t [NUM_COORDS-1:0] digit_next;
  perm_map_t               map_dec;
  perm_idx_t               idx;
  logic                    running;
  logic                    at_last;

  assign at_last = (idx == PERM_IDX_W'(NUM_PERMS - 1));

  // pick coordinates out of a shrinking list of those still free
  always_comb begin
    coord_t [NUM_COORDS-1:0] avail;
    coord_t                  pick;
    for (int k = 0; k < NUM_COORDS; k++) begin
      avail[k] = COORD_W'(k);
    end
    for (int j = 0; j < NUM_COORDS; j++) begin
      pick = digit[j];
      map_dec[j] = avail[pick];
      for (int k = 0; k < NUM_COORDS - 1; k++) begin
        if (COORD_W'(k) >= pick) begin
          avail[k] = avail[k+1];
        end
      end
    end
  end

  always_comb begin
    logic carry;
    carry = 1'b1;
    for (int j = 0; j < NUM_COORDS; j++) begin
      digit_next[j] = digit[j];
      if (carry) begin
        if (digit[j] == COORD_W'(NUM_COORDS - 1 - j)) begin
          digit_next[j] = '0;
        end else begin
          digit_next[j] = digit[j] + COORD_W'(1);
          carry = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      ctl     <= '0;
      idx     <= '0;
      digit   <= '0;
    end else begin
      ctl.valid <= running;
      ctl.last  <= running && at_last;
      if (start) begin
        running <= 1'b1;
        idx     <= '0;
        digit   <= '0;
      end else if (running) begin
        digit <= digit_next;
        idx   <= idx + PERM_IDX_W'(1);
        if (at_last) begin
          running <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (running) begin
      map <= map_dec;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/csupc_mask_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

module csupc_mask_unit
  import csupc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire vec_set_t   vecs,
  input  wire perm_map_t  map,
  input  wire stage_ctl_t in_ctl,
  output mask_t           mask,
  output stage_ctl_t      out_ctl
);

  mask_t mask_comb;

  // bit j of each vector moves to position map[j]
  always_comb begin
    vec_t moved;
    mask_comb = '0;
    for (int i = 0; i < NUM_ELEMS; i++) begin
      for (int k = 0; k < NUM_COORDS; k++) begin
        moved[k] = 1'b0;
        for (int j = 0; j < NUM_COORDS; j++) begin
          if (vecs[i][j] && map[j] == COORD_W'(k)) begin
            moved[k] = 1'b1;
          end
        end
      end
      mask_comb[moved] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl <= '0;
    end else begin
      out_ctl <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ctl.valid) begin
      mask <= mask_comb;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/csupc_best_sel.sv =====
`timescale 1ns / 1ps
`default_nettype none

module csupc_best_sel
  import csupc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire mask_t      mask,
  input  wire stage_ctl_t ctl,
  output mask_t           best,
  output logic            done
);

  mask_t mask_rev;
  mask_t best_rev;
  logic  is_before;

  // lowest differing bit decides, so compare with bit order reversed
  always_comb begin
    for (int t = 0; t < MASK_W; t++) begin
      mask_rev[t] = mask[MASK_W-1-t];
      best_rev[t] = best[MASK_W-1-t];
    end
  end

  assign is_before = (mask_rev > best_rev);

  // an all-zero start loses to any real mask, which always has a set bit
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
      best <= '0;
    end else begin
      done <= ctl.valid && ctl.last;
      if (start) begin
        best <= '0;
      end else if (ctl.valid && is_before) begin
        best <= mask;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/canonical_set_under_coordinate_perm_core.sv =====
// Each item is swept over all 5040 coordinate permutations through the decode,
// mask and compare stages before its result is loaded for output.
// Sweeps of items do not overlap; one permutation is tried per
// cycle through a single mask builder and one 128-bit compare.
// A new item is taken while the previous result still waits at the output.
// Reset (rst, synchronous, active high) returns to idle with no result pending.
`timescale 1ns / 1ps
`default_nettype none

module canonical_set_under_coordinate_perm_core
  import csupc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // element_0 [6:0], element_1 [13:7], ... element_11 [83:77], zeros [87:84]
  input  wire logic [IN_DATA_W-1:0]  s_tdata,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // mask_low [63:0], mask_high [127:64]
  output logic [MASK_W-1:0]          m_tdata
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t     state;
  vec_set_t   vecs;
  logic       start;
  perm_map_t  map;
  stage_ctl_t map_ctl;
  mask_t      mask;
  stage_ctl_t mask_ctl;
  mask_t      best;
  logic       best_done;
  logic       out_load;
  logic [NUM_COORDS-1:0] map_cover;

  assign s_tready = (state == ST_IDLE);
  assign start    = s_tvalid && s_tready;
  assign out_load = (state == ST_DONE) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      // a fresh load wins over the item leaving in the same cycle
      m_tvalid <= out_load || (m_tvalid && !m_tready);
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (best_done) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      for (int i = 0; i < NUM_ELEMS; i++) begin
        vecs[i] <= s_tdata[i*VEC_W +: VEC_W];
      end
    end
    if (out_load) begin
      m_tdata <= best;
    end
  end

  csupc_perm_gen u_perm_gen (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .map   (map),
    .ctl   (map_ctl)
  );

  csupc_mask_unit u_mask_unit (
    .clk     (clk),
    .rst     (rst),
    .vecs    (vecs),
    .map     (map),
    .in_ctl  (map_ctl),
    .mask    (mask),
    .out_ctl (mask_ctl)
  );

  csupc_best_sel u_best_sel (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .mask  (mask),
    .ctl   (mask_ctl),
    .best  (best),
    .done  (best_done)
  );

  always_comb begin
    map_cover = '0;
    for (int j = 0; j < NUM_COORDS; j++) begin
      map_cover[map[j]] = 1'b1;
    end
  end

  a_done_in_run: assert property (@(posedge clk) disable iff (rst)
    best_done |-> state == ST_RUN)
    else $error("sweep finished outside of run state");

  a_map_is_perm: assert property (@(posedge clk) disable iff (rst)
    map_ctl.valid |-> map_cover == {NUM_COORDS{1'b1}})
    else $error("decoded coordinate map is not a permutation");

  a_mask_weight: assert property (@(posedge clk) disable iff (rst)
    mask_ctl.valid |-> ($countones(mask) >= 1 && $countones(mask) <= NUM_ELEMS))
    else $error("mask weight out of range");

  a_best_nonzero: assert property (@(posedge clk) disable iff (rst)
    best_done |-> best != '0)
    else $error("sweep ended with an empty best mask");

endmodule

`default_nettype wire
